### design/tme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tme_pkg: shared types and codes of the tape machine executor
// Transaction payload structs, request op codes, response status codes and
// instruction opcodes.
// ----------------------------------------------------------------------------
package tme_pkg;

   // words on the tape; the address and program counter fields are sized for it
   localparam int TAPE_WORDS = 512;

   // request op codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_EXEC    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // response status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHAR  = 3'd2;
   localparam logic [2:0] ST_NUM   = 3'd3;
   localparam logic [2:0] ST_HALT  = 3'd4;
   localparam logic [2:0] ST_FAULT = 3'd5;

   // instruction opcodes
   localparam logic [3:0] OPC_HALT = 4'd0;
   localparam logic [3:0] OPC_ADD  = 4'd1;
   localparam logic [3:0] OPC_MUL  = 4'd2;
   localparam logic [3:0] OPC_CLT  = 4'd3;
   localparam logic [3:0] OPC_CEQ  = 4'd4;
   localparam logic [3:0] OPC_JMP  = 4'd5;
   localparam logic [3:0] OPC_JNZ  = 4'd6;
   localparam logic [3:0] OPC_CPY  = 4'd7;
   localparam logic [3:0] OPC_PUT  = 4'd8;
   localparam logic [3:0] OPC_PTN  = 4'd9;

   // width of the reported program counter
   localparam int PC_OUT_W = 10;

   typedef struct packed {
      logic [1:0]         op;
      logic [8:0]         address;
      logic signed [31:0] data;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic signed [31:0]    value;
      logic [PC_OUT_W-1:0]   program_counter;
   } rsp_type;

endpackage
`default_nettype wire

### design/tape_machine_executor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tape_machine_executor: stored-program tape machine
// Code and data share one tape memory of signed 32-bit words; each request
// transaction writes, reads, executes one instruction or restarts.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and returns exactly one
// response transaction for it. A sequencer walks each instruction through a
// single-port-read, single-port-write tape memory with registered read data,
// one fetch per cycle: opcode, up to three operand words, up to two operand
// loads, then at most one write. That memory port sets the pace. A finished
// response waits in S_RESP while the response register is full and rsp_stall
// is high. The next request can be accepted at the edge at which the response
// can first be taken. req_stall is high whenever the sequencer is busy. The
// tape has no reset: a word reads as garbage until written. Arithmetic,
// compare and multiply share one unit that operates on the first loaded
// operand and the memory read data.
module tape_machine_executor
   import tme_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int AW  = $clog2(TAPE_WORDS);
   localparam int PCW = $clog2(TAPE_WORDS + 1);
   localparam logic [31:0]  TW32   = 32'(TAPE_WORDS);
   localparam logic [PCW:0] TWX    = (PCW + 1)'(TAPE_WORDS);
   localparam logic [PCW-1:0] PC_END = PCW'(TAPE_WORDS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RDWAIT,
      S_FETCH_OP,
      S_FETCH_A,
      S_FETCH_B,
      S_FETCH_D,
      S_LOAD_X,
      S_LOAD_Y,
      S_RESP
   } state_type;

   function automatic logic addr_ok(input logic [31:0] w);
      return w < TW32;
   endfunction

   // registers
   state_type       state_ff,     state_in;
   logic [PCW-1:0]  pc_ff,        pc_in;
   logic            halted_ff,    halted_in;
   logic [3:0]      opc_ff,       opc_in;
   logic [AW-1:0]   a_ff,         a_in;
   logic [AW-1:0]   b_ff,         b_in;
   logic [AW-1:0]   d_ff,         d_in;
   logic [31:0]     x_ff,         x_in;
   logic [2:0]      st_ff,        st_in;
   logic [31:0]     val_ff,       val_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff,       rsp_in;

   // tape memory
   logic [31:0]     tape_mem [TAPE_WORDS];
   logic [31:0]     mem_rdata_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [31:0]     mem_wdata;
   logic [AW-1:0]   mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= tape_mem[mem_raddr];
   end

   // pc with a spare bit so that operand bounds compare without wrap
   logic [PCW:0]    pc_ext;
   logic [1:0]      need;
   logic [3:0]      fetched_opc;
   logic            rdata_ok;
   logic [AW-1:0]   rdata_idx;
   logic [PCW-1:0]  jump_pc;
   logic [31:0]     alu_out;

   assign pc_ext      = {1'b0, pc_ff};
   assign fetched_opc = mem_rdata_ff[3:0];
   assign rdata_ok    = addr_ok(mem_rdata_ff);
   assign rdata_idx   = mem_rdata_ff[AW-1:0];
   assign jump_pc     = rdata_ok ? PCW'(mem_rdata_ff) : PC_END;

   // operand words that follow the opcode
   always_comb begin
      case (fetched_opc) inside
         OPC_ADD, OPC_MUL, OPC_CLT, OPC_CEQ: need = 2'd3;
         OPC_JNZ, OPC_CPY:                   need = 2'd2;
         default:                            need = 2'd1;
      endcase
   end

   // shared arithmetic and compare unit
   always_comb begin
      case (opc_ff)
         OPC_ADD: alu_out = x_ff + mem_rdata_ff;
         OPC_MUL: alu_out = x_ff * mem_rdata_ff;
         OPC_CLT: alu_out = {31'd0, $signed(x_ff) < $signed(mem_rdata_ff)};
         default: alu_out = {31'd0, x_ff == mem_rdata_ff};
      endcase
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      halted_in    = halted_ff;
      opc_in       = opc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      st_in        = st_ff;
      val_in       = val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = d_ff;
      mem_wdata    = mem_rdata_ff;
      mem_raddr    = AW'(pc_ff);

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in   = '0;
               st_in    = ST_OK;
               state_in = S_RESP;
               unique case (req_payload.op)
                  OP_WRITE: begin
                     if (addr_ok(32'(req_payload.address))) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_payload.address);
                        mem_wdata = req_payload.data;
                     end else begin
                        st_in = ST_FAULT;
                     end
                  end
                  OP_READ: begin
                     if (addr_ok(32'(req_payload.address))) begin
                        mem_raddr = AW'(req_payload.address);
                        state_in  = S_RDWAIT;
                     end else begin
                        st_in = ST_FAULT;
                     end
                  end
                  OP_EXEC: begin
                     if (halted_ff || (pc_ff >= PC_END)) begin
                        halted_in = 1'b1;
                        st_in     = ST_HALT;
                     end else begin
                        mem_raddr = AW'(pc_ff);
                        state_in  = S_FETCH_OP;
                     end
                  end
                  OP_RESTART: begin
                     pc_in     = '0;
                     halted_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_RDWAIT: begin
            st_in    = ST_READ;
            val_in   = mem_rdata_ff;
            state_in = S_RESP;
         end
         S_FETCH_OP: begin
            opc_in = fetched_opc;
            if (mem_rdata_ff > 32'(OPC_PTN)) begin
               st_in    = ST_FAULT;
               state_in = S_RESP;
            end else if (fetched_opc == OPC_HALT) begin
               halted_in = 1'b1;
               pc_in     = PC_END;
               st_in     = ST_HALT;
               state_in  = S_RESP;
            end else if ((pc_ext + (PCW + 1)'(need)) >= TWX) begin
               st_in    = ST_FAULT;
               state_in = S_RESP;
            end else begin
               mem_raddr = AW'(pc_ext + (PCW + 1)'(1));
               state_in  = S_FETCH_A;
            end
         end
         S_FETCH_A: begin
            if (!rdata_ok) begin
               st_in    = ST_FAULT;
               state_in = S_RESP;
            end else begin
               a_in = rdata_idx;
               case (opc_ff) inside
                  OPC_ADD, OPC_MUL, OPC_CLT, OPC_CEQ, OPC_CPY: begin
                     mem_raddr = AW'(pc_ext + (PCW + 1)'(2));
                     state_in  = S_FETCH_B;
                  end
                  default: begin
                     mem_raddr = rdata_idx;
                     state_in  = S_LOAD_X;
                  end
               endcase
            end
         end
         S_FETCH_B: begin
            if (!rdata_ok) begin
               st_in    = ST_FAULT;
               state_in = S_RESP;
            end else begin
               case (opc_ff) inside
                  OPC_ADD, OPC_MUL, OPC_CLT, OPC_CEQ: begin
                     b_in      = rdata_idx;
                     mem_raddr = AW'(pc_ext + (PCW + 1)'(3));
                     state_in  = S_FETCH_D;
                  end
                  OPC_CPY: begin
                     d_in      = rdata_idx;
                     mem_raddr = a_ff;
                     state_in  = S_LOAD_X;
                  end
                  default: begin
                     // taken jnz: load the target word
                     mem_raddr = rdata_idx;
                     state_in  = S_LOAD_Y;
                  end
               endcase
            end
         end
         S_FETCH_D: begin
            if (!rdata_ok) begin
               st_in    = ST_FAULT;
               state_in = S_RESP;
            end else begin
               d_in      = rdata_idx;
               mem_raddr = a_ff;
               state_in  = S_LOAD_X;
            end
         end
         S_LOAD_X: begin
            x_in     = mem_rdata_ff;
            state_in = S_RESP;
            case (opc_ff) inside
               OPC_ADD, OPC_MUL, OPC_CLT, OPC_CEQ: begin
                  mem_raddr = b_ff;
                  state_in  = S_LOAD_Y;
               end
               OPC_JMP: begin
                  if (mem_rdata_ff[31]) begin
                     st_in = ST_FAULT;
                  end else begin
                     pc_in = jump_pc;
                  end
               end
               OPC_JNZ: begin
                  if (mem_rdata_ff == '0) begin
                     pc_in = PCW'(pc_ext + (PCW + 1)'(3));
                  end else begin
                     mem_raddr = AW'(pc_ext + (PCW + 1)'(2));
                     state_in  = S_FETCH_B;
                  end
               end
               OPC_CPY: begin
                  mem_we    = 1'b1;
                  mem_waddr = d_ff;
                  mem_wdata = mem_rdata_ff;
                  pc_in     = PCW'(pc_ext + (PCW + 1)'(3));
               end
               OPC_PUT: begin
                  st_in  = ST_CHAR;
                  val_in = {24'd0, mem_rdata_ff[7:0]};
                  pc_in  = PCW'(pc_ext + (PCW + 1)'(2));
               end
               default: begin
                  st_in  = ST_NUM;
                  val_in = mem_rdata_ff;
                  pc_in  = PCW'(pc_ext + (PCW + 1)'(2));
               end
            endcase
         end
         S_LOAD_Y: begin
            state_in = S_RESP;
            if (opc_ff == OPC_JNZ) begin
               if (mem_rdata_ff[31]) begin
                  st_in = ST_FAULT;
               end else begin
                  pc_in = jump_pc;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = d_ff;
               mem_wdata = alu_out;
               pc_in     = PCW'(pc_ext + (PCW + 1)'(4));
            end
         end
         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status          = st_ff;
               rsp_in.value           = val_ff;
               rsp_in.program_counter = PC_OUT_W'(pc_ff);
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opc_ff <= opc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      x_ff   <= x_in;
      st_ff  <= st_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   // a halted machine always sits at the tape end
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (pc_ff == PC_END))
      else $error("halted with pc short of the tape end");

   // pc never runs past the tape end
   assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_END)
      else $error("pc beyond the tape end");

   // an accepted transaction always occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after acceptance");

   // tape writes come only from a write request, copy or an ALU result
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE || state_ff == S_LOAD_X || state_ff == S_LOAD_Y))
      else $error("tape write from an unexpected state");

endmodule
`default_nettype wire
